// File: src/ahfe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ahfe_pkg: shared definitions for the ASCII hex frame encoder
// Character slot codes, register indexes and the nibble-to-hex function.
// ----------------------------------------------------------------------------
package ahfe_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_HEAD_MARK = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TAIL_MARK = 2'd1;

	localparam logic [BYTE_W-1:0] CKS_BASE = 8'hFF;
	localparam logic [BYTE_W-1:0] HI_MASK = 8'hF0;
	localparam logic [BYTE_W-1:0] LO_MASK = 8'h0F;
	localparam logic [3:0] TEN = 4'hA;

	typedef enum logic [3:0] {
		SLOT_HEAD0,
		SLOT_HEAD1,
		SLOT_HEAD2,
		SLOT_DATA_HI,
		SLOT_DATA_LO,
		SLOT_CKS_HI,
		SLOT_CKS_LO,
		SLOT_TAIL0,
		SLOT_TAIL1,
		SLOT_TAIL2
	} slot_t;

	function automatic logic [BYTE_W-1:0] nibble_char(input logic [3:0] n);
		logic [BYTE_W-1:0] c;
		if (n < TEN) begin
			c = 8'h30 + {4'h0, n};
		end else begin
			c = 8'h41 + {4'h0, n - TEN};
		end
		return c;
	endfunction

endpackage

// File: src/ascii_hex_frame_encoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_hex_frame_encoder: payload bytes to framed ASCII hex characters
// Opens each frame with three head marks, sends every byte as two hex digits,
// then closes with the checksum digits and three tail marks.
// ----------------------------------------------------------------------------
// Each accepted payload beat becomes one output beat per character, one
// character per cycle while out_stall is low: 2 characters for a byte inside
// a frame, 5 for the first byte of a frame, 7 for the last byte and 10 for a
// one-byte frame. The single output register sets the rate; the next input
// beat is taken in the cycle the last character of the current one is
// loaded. Marks written through the configuration port apply to the next
// mark sent.
module ascii_hex_frame_encoder (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [ahfe_pkg::BYTE_W-1:0]           payload_byte,
	input  logic                                  frame_end,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [ahfe_pkg::BYTE_W-1:0]           line_char,
	output logic                                  run_last,
	input  logic                                  cfg_wr_en,
	input  logic [ahfe_pkg::CFG_INDEX_W-1:0]      cfg_index,
	input  logic [ahfe_pkg::BYTE_W-1:0]           cfg_data
);
	import ahfe_pkg::*;

	logic [BYTE_W-1:0] head_mark_q;
	logic [BYTE_W-1:0] tail_mark_q;
	logic [BYTE_W-1:0] running_sum_q;
	logic              frame_open_q;

	logic              busy_s1;
	slot_t             slot_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic [BYTE_W-1:0] cks_s1;
	logic              last_s1;

	logic              out_valid_q;
	logic [BYTE_W-1:0] line_char_q;
	logic              run_last_q;

	logic              accept;
	logic              out_free;
	logic              emit;
	logic              final_slot;
	logic [BYTE_W-1:0] sum_next;
	slot_t             slot_next;
	logic [BYTE_W-1:0] char_cur;

	assign out_free   = !out_valid_q || !out_stall;
	assign emit       = busy_s1 && out_free;
	assign final_slot = last_s1 ? (slot_s1 == SLOT_TAIL2) : (slot_s1 == SLOT_DATA_LO);
	assign in_stall   = busy_s1 && !(emit && final_slot);
	assign accept     = in_valid && !in_stall;
	assign sum_next   = running_sum_q + payload_byte;

	always_comb begin
		case (slot_s1)
			SLOT_HEAD0:   slot_next = SLOT_HEAD1;
			SLOT_HEAD1:   slot_next = SLOT_HEAD2;
			SLOT_HEAD2:   slot_next = SLOT_DATA_HI;
			SLOT_DATA_HI: slot_next = SLOT_DATA_LO;
			SLOT_DATA_LO: slot_next = SLOT_CKS_HI;
			SLOT_CKS_HI:  slot_next = SLOT_CKS_LO;
			SLOT_CKS_LO:  slot_next = SLOT_TAIL0;
			SLOT_TAIL0:   slot_next = SLOT_TAIL1;
			SLOT_TAIL1:   slot_next = SLOT_TAIL2;
			default:      slot_next = SLOT_HEAD0;
		endcase
	end

	always_comb begin
		case (slot_s1)
			SLOT_HEAD0, SLOT_HEAD1, SLOT_HEAD2: char_cur = head_mark_q;
			SLOT_DATA_HI: char_cur = nibble_char(4'((byte_s1 & HI_MASK) >> 4));
			SLOT_DATA_LO: char_cur = nibble_char(4'(byte_s1 & LO_MASK));
			SLOT_CKS_HI:  char_cur = nibble_char(4'((cks_s1 & HI_MASK) >> 4));
			SLOT_CKS_LO:  char_cur = nibble_char(4'(cks_s1 & LO_MASK));
			default:      char_cur = tail_mark_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_mark_q <= '0;
			tail_mark_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_HEAD_MARK: head_mark_q <= cfg_data;
				REG_TAIL_MARK: tail_mark_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_sum_q <= '0;
			frame_open_q  <= 1'b0;
		end else if (accept) begin
			running_sum_q <= frame_end ? '0 : sum_next;
			frame_open_q  <= !frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1 <= 1'b0;
			slot_s1 <= SLOT_HEAD0;
		end else if (accept) begin
			busy_s1 <= 1'b1;
			slot_s1 <= frame_open_q ? SLOT_DATA_HI : SLOT_HEAD0;
		end else if (emit) begin
			busy_s1 <= !final_slot;
			slot_s1 <= slot_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= payload_byte;
			cks_s1  <= CKS_BASE - sum_next;
			last_s1 <= frame_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			line_char_q <= char_cur;
			run_last_q  <= final_slot;
		end
	end

	assign out_valid = out_valid_q;
	assign line_char = line_char_q;
	assign run_last  = run_last_q;

`ifndef SYNTH
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_s1)
		else $error("Accepted beat did not occupy the item register.");

	a_idle_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_s1 |-> !in_stall)
		else $error("Input stalled with no item in progress.");

	a_frame_close: assert property (@(posedge clk) disable iff (!arst_n)
		accept && frame_end |=> !frame_open_q && running_sum_q == '0)
		else $error("Frame state not cleared after the last byte.");

	a_emit_continue: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !final_slot |=> busy_s1 && slot_s1 == $past(slot_next))
		else $error("Character sequence did not advance.");
`endif

endmodule

// File: tb/ascii_hex_frame_encoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_hex_frame_encoder_tb: self-checking bench for the ASCII hex encoder
// Feeds payload frames through a queue-driven driver. A local encoder model
// predicts every character beat, and a monitor checks the beats in order.
// Mark registers change between phases, once in the middle of a frame.
// ----------------------------------------------------------------------------
module ascii_hex_frame_encoder_tb;
	import ahfe_pkg::*;

	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
	localparam int unsigned MARK_REPEAT = 3;
	localparam int unsigned IDLE_PCT = 7;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned STUCK_LIMIT = 3000;
	localparam logic [BYTE_W-1:0] ASCII_ZERO = 8'h30;
	localparam logic [BYTE_W-1:0] ASCII_UPPER_A = 8'h41;

	typedef struct packed {
		logic [BYTE_W-1:0] data;
		logic last;
	} payload_beat_t;

	typedef struct packed {
		logic [BYTE_W-1:0] ch;
		logic last;
	} char_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [BYTE_W-1:0] payload_byte = '0;
	logic frame_end = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [BYTE_W-1:0] line_char;
	logic run_last;
	logic cfg_wr_en = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [BYTE_W-1:0] cfg_data = '0;

	payload_beat_t pending_bytes[$];
	char_beat_t expected_chars[$];
	int unsigned queued_cnt = 0;
	int unsigned accepted_cnt = 0;
	int unsigned error_cnt = 0;
	int unsigned rx_hold_req = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned stuck_cnt = 0;
	logic idle_on = 1'b1;

	logic [BYTE_W-1:0] head_copy = '0;
	logic [BYTE_W-1:0] tail_copy = '0;
	logic [BYTE_W-1:0] byte_sum = '0;
	logic in_frame = 1'b0;

	ascii_hex_frame_encoder dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.payload_byte(payload_byte),
		.frame_end(frame_end),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.line_char(line_char),
		.run_last(run_last),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return ASCII_ZERO + {4'h0, nib};
		end
		return ASCII_UPPER_A + {4'h0, nib} - 8'd10;
	endfunction

	function automatic void push_char(input logic [BYTE_W-1:0] ch, input logic last);
		expected_chars.push_back('{ch, last});
	endfunction

	// Appends the characters that one accepted payload beat produces.
	function automatic void encode_byte(input payload_beat_t b);
		logic [BYTE_W-1:0] cks;
		if (!in_frame) begin
			for (int unsigned i = 0; i < MARK_REPEAT; i++) begin
				push_char(head_copy, 1'b0);
			end
			in_frame = 1'b1;
		end
		push_char(hex_digit(b.data[7:4]), 1'b0);
		push_char(hex_digit(b.data[3:0]), !b.last);
		byte_sum = byte_sum + b.data;
		if (b.last) begin
			cks = CKS_BASE - byte_sum;
			push_char(hex_digit(cks[7:4]), 1'b0);
			push_char(hex_digit(cks[3:0]), 1'b0);
			for (int unsigned i = 0; i < MARK_REPEAT; i++) begin
				push_char(tail_copy, i == MARK_REPEAT - 1);
			end
			byte_sum = '0;
			in_frame = 1'b0;
		end
	endfunction

	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return BYTE_W'($urandom_range(255));
		endcase
	endfunction

	always @(posedge clk) begin : driver
		payload_beat_t nxt;
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				encode_byte('{payload_byte, frame_end});
				accepted_cnt++;
			end
			if (!in_valid || !in_stall) begin
				if (pending_bytes.size() != 0 && !(idle_on && $urandom_range(99) < IDLE_PCT)) begin
					nxt = pending_bytes.pop_front();
					in_valid <= 1'b1;
					payload_byte <= nxt.data;
					frame_end <= nxt.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : monitor
		char_beat_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_chars.size() == 0) begin
					$display("%0t: unexpected beat, expected none, actual char %h last %b",
						$time, line_char, run_last);
					error_cnt++;
				end else begin
					want = expected_chars.pop_front();
					if (line_char !== want.ch) begin
						$display("%0t: line_char mismatch, expected %h, actual %h",
							$time, want.ch, line_char);
						error_cnt++;
					end
					if (run_last !== want.last) begin
						$display("%0t: run_last mismatch, expected %b, actual %b",
							$time, want.last, run_last);
						error_cnt++;
					end
				end
			end
			if (hold_seen != rx_hold_req) begin
				hold_seen = rx_hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= idle_on && ($urandom_range(99) < IDLE_PCT);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
			(queued_cnt == accepted_cnt && expected_chars.size() == 0)) begin
			stuck_cnt = 0;
		end else begin
			stuck_cnt++;
		end
		if (stuck_cnt >= STUCK_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic add_byte(input logic [BYTE_W-1:0] d, input logic last);
		pending_bytes.push_back('{d, last});
		queued_cnt++;
	endtask

	task automatic add_frames(input int unsigned target);
		int unsigned n;
		int unsigned len;
		n = 0;
		while (n < target) begin
			len = ($urandom_range(3) == 0) ? 1 : $urandom_range(8, 2);
			for (int unsigned i = 1; i <= len; i++) begin
				add_byte(pick_byte(), i == len);
			end
			n += len;
		end
	endtask

	// The sender holds back until every expected character has come out.
	task automatic drain();
		while (accepted_cnt != queued_cnt || expected_chars.size() != 0) begin
			@(posedge clk);
		end
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		if (idx == REG_HEAD_MARK) begin
			head_copy = val;
		end else if (idx == REG_TAIL_MARK) begin
			tail_copy = val;
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// One-byte frames with the marks still at their reset value.
		add_byte(8'h00, 1'b1);
		add_byte(8'hFF, 1'b1);
		drain();

		write_reg(REG_HEAD_MARK, 8'hFF);
		write_reg(REG_TAIL_MARK, 8'h00);
		write_reg(REG_SPARE_A, 8'h55);
		write_reg(REG_SPARE_B, 8'hAA);
		cfg_wr_en <= 1'b0;
		add_byte(8'h00, 1'b0);
		add_byte(8'hFF, 1'b0);
		add_byte(8'h0A, 1'b0);
		add_byte(8'h09, 1'b0);
		add_byte(8'hA0, 1'b1);
		add_byte(8'h5A, 1'b0);
		add_byte(8'hA5, 1'b1);
		add_byte(8'h01, 1'b0);
		add_byte(8'hFE, 1'b1);
		drain();

		// New marks written while a frame is open.
		write_reg(REG_HEAD_MARK, 8'h23);
		write_reg(REG_TAIL_MARK, 8'h24);
		cfg_wr_en <= 1'b0;
		add_byte(8'h7E, 1'b0);
		drain();
		write_reg(REG_TAIL_MARK, 8'h0D);
		write_reg(REG_HEAD_MARK, 8'h3A);
		cfg_wr_en <= 1'b0;
		add_byte(8'h81, 1'b1);
		add_byte(8'hC3, 1'b1);
		drain();

		write_reg(REG_HEAD_MARK, BYTE_W'($urandom_range(255)));
		write_reg(REG_TAIL_MARK, BYTE_W'($urandom_range(255)));
		cfg_wr_en <= 1'b0;
		add_frames(64);
		drain();

		idle_on <= 1'b0;
		write_reg(REG_HEAD_MARK, 8'h00);
		write_reg(REG_TAIL_MARK, 8'hFF);
		cfg_wr_en <= 1'b0;
		add_frames(55);
		drain();

		// The receiver holds off while the sender keeps offering beats.
		idle_on <= 1'b1;
		write_reg(REG_HEAD_MARK, 8'hFF);
		write_reg(REG_TAIL_MARK, 8'hFF);
		cfg_wr_en <= 1'b0;
		rx_hold_req <= rx_hold_req + 1;
		add_frames(72);
		drain();

		repeat (20) @(posedge clk);
		if (error_cnt == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
